### hw/rtl/mdi_pkg.sv
// Shared constants for the mirror/decimate/invert to I420 block.
// Frame geometry, derived widths and stream packing sizes; no dependencies.
`default_nettype none

package mdi_pkg;

    localparam int SRC_WIDTH  = 640;
    localparam int SRC_HEIGHT = 480;

    localparam int OUT_W = SRC_WIDTH / 2;
    localparam int OUT_H = SRC_HEIGHT / 2;

    localparam int COL_W  = $clog2(SRC_WIDTH);
    localparam int ROW_W  = $clog2(SRC_HEIGHT);
    localparam int ADDR_W = $clog2(OUT_W);

    localparam int PIX_W  = 24;     // {Y, Cb, Cr}, already inverted
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    localparam logic [7:0] FULL = 8'd255;

endpackage

`default_nettype wire

### hw/rtl/mirror_decimate_invert_to_i420.sv
// Mirror, 2x decimate and invert a YUV 4:4:4 raster stream into I420 order.
// Uses mdi_pkg (geometry, widths) and mdi_ram (line buffer).
//
// Usage:
//   Slave channel s_*: one source pixel per request, raster order.
//     s_tdata = {Cr, Cb, Y}, s_tuser = frame start (resets row/column).
//   Master channel m_*: one output pixel per request, output raster order.
//     m_tuser = chroma valid (even output row and column), m_tlast = last
//     pixel of the output frame.
//   Even source rows are inverted (255 - v) and written mirrored into a
//   line buffer; during the next odd row every even column reads one entry
//   back and emits it.
//   Path: after its request is taken, an emitting pixel is read from the
//   line buffer and then loaded into the output register that drives m_tvalid.
//   Throughput: one source pixel per cycle unless the input stalls, set by the single line buffer
//   read port and the one-entry read stage in front of the output register.
//   Stall: while m_tready is low the output register and the read stage
//   hold; the input stalls only once both are full, so a pixel is still
//   taken while a finished result waits.
//   Reset: counters at row 0 column 0, both stages empty. The line buffer
//   is not cleared; it is always written before it is read.
`default_nettype none

module mirror_decimate_invert_to_i420 (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mdi_pkg::S_DATA_W-1:0]   s_tdata,   // src_luma, src_cb, src_cr
    input  wire logic                           s_tuser,   // frame_start
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mdi_pkg::M_DATA_W-1:0]   m_tdata,   // out_col, out_row, out_luma,
                                                           // out_cb, out_cr, zero pad
    output logic                                m_tuser,   // chroma_valid
    output logic                                m_tlast    // frame_last
);

    import mdi_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SRC_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SRC_HEIGHT - 1);
    localparam logic [COL_W-1:0] OX_LIM   = COL_W'(OUT_W);
    localparam logic [ROW_W-1:0] OY_LIM   = ROW_W'(OUT_H);
    localparam logic [COL_W-1:0] OX_END   = COL_W'(OUT_W - 1);
    localparam logic [ROW_W-1:0] OY_END   = ROW_W'(OUT_H - 1);

    typedef struct packed {
        logic [8:0] col;
        logic [7:0] row;
        logic       chroma;
        logic       last;
    } meta_t;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // read stage and output register
    logic             s1_valid_reg;
    meta_t            s1_meta_reg;
    logic             out_valid_reg;
    meta_t            out_meta_reg;
    logic [7:0]       out_luma_reg, out_cb_reg, out_cr_reg;

    logic             accept;
    logic             out_free;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] d;
    logic [COL_W-1:0] ox_st, ox_em;
    logic [ROW_W-1:0] oy;
    logic             oy_ok;
    logic             do_store, do_emit;
    logic [PIX_W-1:0] wr_pix, rd_pix;
    meta_t            meta_in;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // frame start forces position 0,0 for this pixel
    assign c = s_tuser ? '0 : col_reg;
    assign r = s_tuser ? '0 : row_reg;

    assign d     = COL_LAST - c;
    assign ox_st = {1'b0, d[COL_W-1:1]};
    assign ox_em = {1'b0, c[COL_W-1:1]};
    assign oy    = {1'b0, r[ROW_W-1:1]};
    assign oy_ok = oy < OY_LIM;

    assign do_store = !r[0] && !d[0] && (ox_st < OX_LIM) && oy_ok;
    assign do_emit  = r[0] && !c[0] && (ox_em < OX_LIM) && oy_ok;

    assign meta_in.col    = ox_em[8:0];
    assign meta_in.row    = oy[7:0];
    assign meta_in.chroma = !ox_em[0] && !oy[0];
    assign meta_in.last   = (ox_em == OX_END) && (oy == OY_END);

    assign wr_pix = {FULL - s_tdata[7:0], FULL - s_tdata[15:8], FULL - s_tdata[23:16]};

    mdi_ram #(
        .WIDTH (PIX_W),
        .DEPTH (OUT_W)
    ) u_line (
        .clk   (clk),
        .we    (accept && do_store),
        .waddr (ox_st[ADDR_W-1:0]),
        .wdata (wr_pix),
        .re    (accept && do_emit),
        .raddr (ox_em[ADDR_W-1:0]),
        .rdata (rd_pix)
    );

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (c == COL_LAST)
            begin
                col_next = '0;
                row_next = (r == ROW_LAST) ? '0 : r + 1'b1;
            end
            else
            begin
                col_next = c + 1'b1;
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_tready)
            begin
                s1_valid_reg <= accept && do_emit;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_emit)
        begin
            s1_meta_reg <= meta_in;
        end
        if (out_free && s1_valid_reg)
        begin
            out_meta_reg <= s1_meta_reg;
            out_luma_reg <= rd_pix[23:16];
            out_cb_reg   <= s1_meta_reg.chroma ? rd_pix[15:8] : 8'd0;
            out_cr_reg   <= s1_meta_reg.chroma ? rd_pix[7:0] : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_cr_reg, out_cb_reg, out_luma_reg,
                       out_meta_reg.row, out_meta_reg.col};
    assign m_tuser  = out_meta_reg.chroma;
    assign m_tlast  = out_meta_reg.last;

    // read stage stuck behind a stalled output blocks the input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !s_tready)
        else $error("input taken while read stage is stalled");

    // a pixel never both writes and reads the line buffer
    a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(do_store && do_emit))
        else $error("store and emit on the same pixel");

    // an emitting request lands in the read stage
    a_emit_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && do_emit) |=> s1_valid_reg)
        else $error("emitted pixel lost before read stage");

    // chroma bytes are zero off the chroma grid
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[40:25] == 16'd0))
        else $error("chroma carried off the chroma grid");

    // frame end sits on the last output column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[8:0] == 9'(OUT_W - 1)))
        else $error("frame end off the last column");

endmodule

`default_nettype wire

### hw/rtl/mdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module mdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for mirror_decimate_invert_to_i420: drives a YUV 4:4:4 raster stream with
// random idling on both sides; a scoreboard class predicts each I420 output pixel.
// Depends on mdi_pkg and the RTL top level only.

module testbench;
    import mdi_pkg::*;

    typedef struct packed {
        logic [8:0] col;
        logic [7:0] row;
        logic [7:0] luma;
        logic       chroma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       last;
    } i420_pixel_t;

    class i420_scoreboard;
        logic [PIX_W-1:0] line_buf [OUT_W];
        int unsigned      col_pos;
        int unsigned      row_pos;
        i420_pixel_t      pending_q [$];
        int               errors;
        int               pixels_in;
        int               pixels_out;
        int               frame_ends;

        function new();
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            pixels_in  = 0;
            pixels_out = 0;
            frame_ends = 0;
        endfunction

        // one accepted source pixel: update the line buffer or predict an output pixel
        function void note_pixel(logic [S_DATA_W-1:0] data, logic frame_start);
            logic [7:0]       y_inv;
            logic [7:0]       cb_inv;
            logic [7:0]       cr_inv;
            logic [PIX_W-1:0] px;
            int unsigned      mirror_d;
            int unsigned      ox;
            int unsigned      oy;
            i420_pixel_t      p;
            y_inv  = FULL - data[7:0];
            cb_inv = FULL - data[15:8];
            cr_inv = FULL - data[23:16];
            pixels_in++;
            if (frame_start)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            oy = row_pos / 2;
            if (row_pos % 2 == 0)
            begin
                // kept row, stored mirrored
                mirror_d = SRC_WIDTH - 1 - col_pos;
                if (mirror_d % 2 == 0)
                begin
                    ox = mirror_d / 2;
                    if (ox < OUT_W && oy < OUT_H)
                        line_buf[ox] = {y_inv, cb_inv, cr_inv};
                end
            end
            else if (col_pos % 2 == 0)
            begin
                ox = col_pos / 2;
                if (ox < OUT_W && oy < OUT_H)
                begin
                    px       = line_buf[ox];
                    p.col    = 9'(ox);
                    p.row    = 8'(oy);
                    p.luma   = px[23:16];
                    p.chroma = (ox % 2 == 0) && (oy % 2 == 0);
                    p.cb     = p.chroma ? px[15:8] : 8'd0;
                    p.cr     = p.chroma ? px[7:0] : 8'd0;
                    p.last   = (ox == OUT_W - 1) && (oy == OUT_H - 1);
                    pending_q.push_back(p);
                end
            end
            col_pos++;
            if (col_pos >= SRC_WIDTH)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= SRC_HEIGHT)
                    row_pos = 0;
            end
        endfunction

        function void check_field(string name, logic [8:0] exp_val, logic [8:0] act_val);
            if (act_val !== exp_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_output(logic [M_DATA_W-1:0] data, logic chroma, logic last);
            i420_pixel_t exp_px;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output pixel, expected none actual col %0d row %0d",
                         $time, data[8:0], data[16:9]);
                return;
            end
            exp_px = pending_q.pop_front();
            pixels_out++;
            if (last === 1'b1)
                frame_ends++;
            check_field("out_col", exp_px.col, data[8:0]);
            check_field("out_row", {1'b0, exp_px.row}, {1'b0, data[16:9]});
            check_field("out_luma", {1'b0, exp_px.luma}, {1'b0, data[24:17]});
            check_field("out_cb", {1'b0, exp_px.cb}, {1'b0, data[32:25]});
            check_field("out_cr", {1'b0, exp_px.cr}, {1'b0, data[40:33]});
            check_field("chroma_valid", {8'd0, exp_px.chroma}, {8'd0, chroma});
            check_field("frame_last", {8'd0, exp_px.last}, {8'd0, last});
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // src_luma, src_cb, src_cr
    logic                s_tuser  = 1'b0;   // frame_start
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // out_col, out_row, out_luma, out_cb, out_cr, pad
    logic                m_tuser;           // chroma_valid
    logic                m_tlast;           // frame_last

    bit                  calm = 1'b0;       // no idling on either side while set
    i420_scoreboard      sb = new();

    mirror_decimate_invert_to_i420 u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // both handshakes observed on pre-edge values
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99, 0) >= 22);
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_output(m_tdata, m_tuser, m_tlast);
        end
    end

    task send_pixel(input logic [S_DATA_W-1:0] pix, input logic frame_start);
        while (!calm && $urandom_range(99, 0) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= frame_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function logic [S_DATA_W-1:0] rand_pix();
        case ($urandom_range(7, 0))
            0:       rand_pix = '0;
            1:       rand_pix = '1;
            default: rand_pix = S_DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int  n;
        int  len;
        int  i;
        bit  first;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of every component, repeated and isolated frame starts
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'h55AA55, 1'b0);
        send_pixel(24'hAA55AA, 1'b0);
        send_pixel(24'h808080, 1'b1);

        // mostly complete row pairs after a frame start, some cut short
        n     = 0;
        first = 1'b1;
        while (n < 1450)
        begin
            if (first || $urandom_range(9, 0) < 6)
                len = $urandom_range(2 * SRC_WIDTH + 440, 2 * SRC_WIDTH);
            else
                len = $urandom_range(400, 1);
            if (len > 1450 - n)
                len = 1450 - n;
            first = 1'b0;
            for (i = 0; i < len; i++)
            begin
                // one long stretch with no idling on either side
                calm = (n + i >= 300) && (n + i < 1000);
                send_pixel(rand_pix(), i == 0);
            end
            n += len;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        for (n = 0; n < 4000 && sb.pending_q.size() != 0; n++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.pending_q.size() != 0)
        begin
            sb.errors += sb.pending_q.size();
            $display("%0t: %0d output pixels never arrived", $time, sb.pending_q.size());
        end

        $display("Sent %0d source pixels in runs after frame starts; checked %0d outputs.",
                 sb.pixels_in, sb.pixels_out);
        $display("Frame ends seen: %0d, failures: %0d", sb.frame_ends, sb.errors);
        if (sb.errors == 0)
            $display("[mirror_decimate_invert_to_i420] OK");
        else
            $display("[mirror_decimate_invert_to_i420] ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout waiting for the stream to finish");
        $display("[mirror_decimate_invert_to_i420] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mdi_pkg.sv
hw/rtl/mdi_ram.sv
hw/rtl/mirror_decimate_invert_to_i420.sv
tb/sv/testbench.sv
